// ===== design/srd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg
// Shared constants and types for the replacement core.
// ----------------------------------------------------------------------------
package srd_pkg;
    localparam int NUM_SETS_DEF    = 2048;
    localparam int NUM_WAYS_DEF    = 16;
    localparam int SIG_BITS        = 6;
    localparam int SIG_ENTRIES     = 64;
    localparam int ADDR_W          = 64;
    localparam int CONF_MAX        = 7;
    localparam int SEL_MID         = 128;
    localparam int THR_W           = 5;
    localparam int LEADER_GROUPS   = 16;
    localparam int LEADER_DIV      = 32;
    localparam logic [1:0] PRIO_MAX  = 2'd3;
    localparam logic [1:0] PRIO_BIP  = 2'd1;
    localparam logic [1:0] PRIO_HOT  = 2'd0;
    localparam logic ACT_VICTIM = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;
    localparam logic [0:0] REG_STREAM_THR = 1'b0;
    localparam logic [0:0] REG_REUSE_THR  = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic read;
        logic exec;
    } srd_cmd_t;

    typedef struct packed {
        logic clr_done;
    } srd_sts_t;
endpackage
`default_nettype wire

// ===== design/ship_rrip_dip_stream_replacement_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ship_rrip_dip_stream_replacement_core
// RRIP replacement with SHiP reuse table, DIP set duelling and stride
// stream detection.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (action, set, way, address, pc, hit); each
// produces exactly one result item on m_axis (victim way, streaming flag).
// Per item: the accepting edge also reads the set row and the set's detector
// entry, the read state then reads the reuse counter, and the execute state
// computes and writes back. No new item is accepted until the execute state
// has finished, and the result is registered by the execute step.
// The result sits in an output register; the next item is accepted while
// it waits, but its write-back holds until the register frees.
// After aresetn the core sweeps all NUM_SETS entries to
// restore priorities to 3, clear signatures and detectors and set the reuse
// counters to 1; s_axis_tready stays low meanwhile. Configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
module ship_rrip_dip_stream_replacement_core #(
    parameter int NUM_SETS = srd_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = srd_pkg::NUM_WAYS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[0], set_index[11:1], way_index[15:12], phys_addr[79:16],
    // prog_counter[143:80], was_hit[144], zero pad
    input  wire logic [151:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // victim_way[3:0], set_streaming[4], zero pad
    output logic [7:0]        m_axis_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_index,
    input  wire logic [2:0]   cfg_wr_data
);
    srd_pkg::srd_cmd_t cmd;
    srd_pkg::srd_sts_t sts;
    logic [3:0] victim;
    logic       streaming;

    srd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_full (m_axis_tvalid && !m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srd_datapath #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_action     (s_axis_tdata[0]),
        .in_set        (s_axis_tdata[11:1]),
        .in_way        (s_axis_tdata[15:12]),
        .in_addr       (s_axis_tdata[79:16]),
        .in_pc         (s_axis_tdata[143:80]),
        .in_hit        (s_axis_tdata[144]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_victim    (victim),
        .out_streaming (streaming)
    );

    assign m_axis_tdata = {3'b000, streaming, victim};
endmodule
`default_nettype wire

// ===== design/srd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_ctrl
// Sequencer: clearing pass after reset, then load / read / execute per item.
// ----------------------------------------------------------------------------
module srd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_full,
    input  wire srd_pkg::srd_sts_t sts,
    output srd_pkg::srd_cmd_t     cmd
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!out_full) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.clr_step, cmd.read, cmd.exec}))
        else $error("srd_ctrl: more than one command");
    a_read_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.read)
        else $error("srd_ctrl: load not followed by read");
    a_no_ready_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !in_ready)
        else $error("srd_ctrl: ready during clearing pass");
endmodule
`default_nettype wire

// ===== design/srd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_datapath
// Set row and per-set detector memories, reuse table, selector and
// the victim / update arithmetic.
// ----------------------------------------------------------------------------
module srd_datapath #(
    parameter int NUM_SETS = srd_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = srd_pkg::NUM_WAYS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srd_pkg::srd_cmd_t cmd,
    output srd_pkg::srd_sts_t      sts,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_index,
    input  wire logic [2:0]        cfg_wr_data,
    input  wire logic              in_action,
    input  wire logic [10:0]       in_set,
    input  wire logic [3:0]        in_way,
    input  wire logic [63:0]       in_addr,
    input  wire logic [63:0]       in_pc,
    input  wire logic              in_hit,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [3:0]             out_victim,
    output logic                   out_streaming
);
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AW    = srd_pkg::ADDR_W;
    localparam int SW    = srd_pkg::SIG_BITS;
    localparam int ROWW  = 2 * NUM_WAYS;
    localparam int SROWW = SW * NUM_WAYS;
    localparam int DETW  = 2 * AW + 3;

    // memories
    logic [ROWW-1:0]  prio_mem [NUM_SETS];
    logic [SROWW-1:0] sig_mem  [NUM_SETS];
    logic [DETW-1:0]  det_mem  [NUM_SETS];
    logic [1:0]       reuse_mem [srd_pkg::SIG_ENTRIES];

    logic [ROWW-1:0]  prio_rd_reg;
    logic [SROWW-1:0] sig_rd_reg;
    logic [DETW-1:0]  det_rd_reg;
    logic [1:0]       cnt_reg;

    logic [SET_W:0]   clr_cnt_reg;
    logic [2:0]       stream_thr_reg;
    logic [1:0]       reuse_thr_reg;
    logic [7:0]       sel_reg;
    logic [srd_pkg::THR_W-1:0] thr_reg;

    logic              act_reg, hit_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [AW-1:0]     addr_reg;
    logic [SW-1:0]     pcsig_reg;
    logic              lip_reg, bip_reg;

    logic              out_valid_reg;
    logic [3:0]        out_victim_reg;
    logic              out_stream_reg;

    // leader test on the incoming set
    function automatic logic is_lip(input logic [SET_W-1:0] s);
        logic r;
        r = 1'b0;
        for (int i = 0; i < srd_pkg::LEADER_GROUPS; i++)
            if (s == SET_W'((i * NUM_SETS) / srd_pkg::LEADER_DIV)) r = 1'b1;
        return r;
    endfunction

    logic [SET_W-1:0] in_set_m;
    logic [SET_W-1:0] in_set_dec;
    assign in_set_m   = in_set[SET_W-1:0];
    assign in_set_dec = in_set_m - SET_W'(1);

    logic [SW-1:0] in_sig;
    assign in_sig = in_pc[SW-1:0] ^ in_pc[2*SW-1:SW] ^ in_pc[3*SW-1:2*SW];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= in_action;
            hit_reg   <= in_hit;
            set_reg   <= in_set_m;
            way_reg   <= in_way[WAY_W-1:0];
            addr_reg  <= in_addr;
            pcsig_reg <= in_sig;
            lip_reg   <= is_lip(in_set_m);
            bip_reg   <= !is_lip(in_set_m) && (in_set_m != '0) && is_lip(in_set_dec);
        end
    end

    // clearing pass
    assign sts.clr_done = (clr_cnt_reg == (SET_W+1)'(NUM_SETS - 1));
    always_ff @(posedge aclk) begin
        if (!aresetn)          clr_cnt_reg <= '0;
        else if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + (SET_W+1)'(1);
    end

    // set row and detector read on the accepting edge
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prio_rd_reg <= prio_mem[in_set_m];
            sig_rd_reg  <= sig_mem[in_set_m];
            det_rd_reg  <= det_mem[in_set_m];
        end
    end

    // execute logic
    logic [AW-1:0] prev_a, prev_s, stride;
    logic [2:0]    conf, conf_new;
    logic          streaming_new, streaming_old;
    logic [1:0]    top, add;
    logic [ROWW-1:0] aged, row_upd;
    logic [SROWW-1:0] sig_upd;
    logic [WAY_W-1:0] vic;
    logic          found;
    logic [SW-1:0] old_sig;
    logic [SW-1:0] reuse_idx;
    logic [1:0]    prio;

    assign prev_a = det_rd_reg[AW-1:0];
    assign prev_s = det_rd_reg[2*AW-1:AW];
    assign conf   = det_rd_reg[DETW-1:2*AW];
    assign stride = addr_reg - prev_a;
    assign old_sig = sig_rd_reg[way_reg*SW +: SW];
    // hit trains the stored signature, fill the new one
    assign reuse_idx = hit_reg ? old_sig : pcsig_reg;

    // read stage: reuse counter
    always_ff @(posedge aclk) begin
        if (cmd.read) cnt_reg <= reuse_mem[reuse_idx];
    end

    always_comb begin
        if (prev_a != '0 && stride == prev_s)
            conf_new = (conf == 3'(srd_pkg::CONF_MAX)) ? conf : conf + 3'd1;
        else
            conf_new = (conf == 3'd0) ? conf : conf - 3'd1;
        streaming_new = conf_new >= stream_thr_reg;
        streaming_old = conf >= stream_thr_reg;

        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            if (prio_rd_reg[2*w +: 2] > top) top = prio_rd_reg[2*w +: 2];
        add = srd_pkg::PRIO_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++)
            aged[2*w +: 2] = prio_rd_reg[2*w +: 2] + add;
        vic   = '0;
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
            if (!found && aged[2*w +: 2] == srd_pkg::PRIO_MAX) begin
                found = 1'b1;
                vic   = WAY_W'(w);
            end

        if (streaming_new || lip_reg) prio = srd_pkg::PRIO_MAX;
        else if (bip_reg)
            prio = (thr_reg == '0) ? srd_pkg::PRIO_MAX : srd_pkg::PRIO_BIP;
        else
            prio = (sel_reg >= 8'(srd_pkg::SEL_MID)) ? srd_pkg::PRIO_MAX
                                                     : srd_pkg::PRIO_BIP;
        if (cnt_reg >= reuse_thr_reg) prio = srd_pkg::PRIO_HOT;

        row_upd = prio_rd_reg;
        row_upd[way_reg*2 +: 2] = hit_reg ? srd_pkg::PRIO_HOT : prio;
        sig_upd = sig_rd_reg;
        if (!hit_reg) sig_upd[way_reg*SW +: SW] = pcsig_reg;
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            prio_mem[clr_cnt_reg[SET_W-1:0]] <= {NUM_WAYS{srd_pkg::PRIO_MAX}};
            sig_mem[clr_cnt_reg[SET_W-1:0]]  <= '0;
            det_mem[clr_cnt_reg[SET_W-1:0]]  <= '0;
        end else if (cmd.exec) begin
            if (act_reg == srd_pkg::ACT_VICTIM) begin
                prio_mem[set_reg] <= aged;
            end else begin
                prio_mem[set_reg] <= row_upd;
                sig_mem[set_reg]  <= sig_upd;
                det_mem[set_reg]  <= {conf_new, stride, addr_reg};
            end
        end
    end

    // reuse counters, set to 1 by the clearing pass
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            reuse_mem[clr_cnt_reg[SW-1:0]] <= 2'd1;
        end else if (cmd.exec && act_reg == srd_pkg::ACT_UPDATE) begin
            if (hit_reg) begin
                if (cnt_reg != 2'd3) reuse_mem[reuse_idx] <= cnt_reg + 2'd1;
            end else begin
                if (cnt_reg != 2'd0) reuse_mem[reuse_idx] <= cnt_reg - 2'd1;
            end
        end
    end

    // scalar state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_thr_reg <= 3'd5;
            reuse_thr_reg  <= 2'd2;
            sel_reg        <= 8'(srd_pkg::SEL_MID);
            thr_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == srd_pkg::REG_STREAM_THR) stream_thr_reg <= cfg_wr_data;
                else                                         reuse_thr_reg  <= cfg_wr_data[1:0];
            end
            if (cmd.exec && act_reg == srd_pkg::ACT_UPDATE) begin
                if (hit_reg) begin
                    if (lip_reg && sel_reg != 8'hFF) sel_reg <= sel_reg + 8'd1;
                    if (bip_reg && sel_reg != 8'h00) sel_reg <= sel_reg - 8'd1;
                end else begin
                    if (bip_reg && !streaming_new)
                        thr_reg <= thr_reg + srd_pkg::THR_W'(1);
                    if (lip_reg && sel_reg != 8'h00) sel_reg <= sel_reg - 8'd1;
                    if (bip_reg && sel_reg != 8'hFF) sel_reg <= sel_reg + 8'd1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (cmd.exec) out_valid_reg <= 1'b1;
        else if (out_ready) out_valid_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_victim_reg <= (act_reg == srd_pkg::ACT_VICTIM) ? 4'(vic) : 4'd0;
            out_stream_reg <= (act_reg == srd_pkg::ACT_VICTIM) ? streaming_old
                                                               : streaming_new;
        end
    end
    assign out_valid     = out_valid_reg;
    assign out_victim    = out_victim_reg;
    assign out_streaming = out_stream_reg;

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("srd_datapath: result overwritten");
    a_update_way0: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && act_reg == srd_pkg::ACT_UPDATE) |=> out_victim_reg == 4'd0)
        else $error("srd_datapath: update returned non-zero way");
    a_sel_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.exec) |-> $stable(sel_reg))
        else $error("srd_datapath: selector moved without an item");
endmodule
`default_nettype wire
